>>> hdl/mlpf_pkg.sv
// ----------------------------------------------------------------------------
// mlpf_pkg
// Shared sizes, codes and helpers for the multi-level priority FIFO core.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpf_pkg;

  // Queue geometry
  localparam int LEVELS     = 8;
  localparam int CAPACITY   = 256;
  localparam int VALUE_BITS = 32;

  localparam int LVL_W  = $clog2(LEVELS);
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ACT_W  = $clog2(LEVELS + 1);

  // Port field widths
  localparam int CMD_W       = 2;
  localparam int PRI_W       = 3;
  localparam int STAT_W      = 2;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 56;

  // Request kinds
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_SPARE = 2'd3
  } mlpf_cmd_t;

  // Completion codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_POP_EMPTY = 2'd1,
    STAT_PUSH_FULL = 2'd2,
    STAT_SPARE     = 2'd3
  } mlpf_status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HEAD,
    ST_OUT
  } mlpf_state_t;

  // Advance a free-ring pointer with wraparound
  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W-1:0] res;
    if (idx == SLOT_W'(CAPACITY - 1)) begin
      res = '0;
    end else begin
      res = idx + SLOT_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/multi_level_priority_fifo_core.sv
// ----------------------------------------------------------------------------
// multi_level_priority_fifo_core
// Priority queue with one FIFO per level over a shared linked entry store.
// ----------------------------------------------------------------------------
//  channel | ports         | tdata (low bit up)                      | tuser
//  --------+---------------+-----------------------------------------+-----------
//  in      | in_t*         | value[31:0], priority_req[34:32], pad    | cmd[1:0]
//  out     | out_t*        | head_value[31:0], is_empty[32],          | status[1:0]
//          |               | total_count[41:33], level_count[50:42],  |
//          |               | active_levels[54:51], pad                |
//
// A request is taken only in idle, and the next one waits until its result loads:
// accept with the first memory read, update, head value read, result load.
// The pop path sets these steps: link read, then value read of the new head.
// Reset is synchronous; a fill count stands in for the initial free-ring slot
// numbers, so the core is ready right after reset.
// A waiting result does not block the next request; only the next load waits.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_level_priority_fifo_core
  import mlpf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_DATA_W-1:0]   in_tdata,   // value, priority_req, pad
  input  wire logic [CMD_W-1:0]       in_tuser,   // cmd
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_DATA_W-1:0]  out_tdata,  // head_value, is_empty, total_count,
                                                  // level_count, active_levels, pad
  output      logic [STAT_W-1:0]      out_tuser   // status
);

  // Memories
  logic [VALUE_BITS-1:0] val_mem  [CAPACITY];
  logic [SLOT_W-1:0]     link_mem [CAPACITY];
  logic [SLOT_W-1:0]     free_mem [CAPACITY];

  logic [VALUE_BITS-1:0] val_q;
  logic [SLOT_W-1:0]     link_q;
  logic [SLOT_W-1:0]     free_q;

  logic                  val_we;
  logic [SLOT_W-1:0]     val_wa;
  logic                  link_we;
  logic [SLOT_W-1:0]     link_wa;
  logic                  free_we;
  logic [SLOT_W-1:0]     rd_addr;

  // Level bookkeeping
  logic [SLOT_W-1:0]     heads_r [LEVELS];
  logic [SLOT_W-1:0]     tails_r [LEVELS];
  logic [CNT_W-1:0]      cnt_r   [LEVELS];
  logic [CNT_W-1:0]      held_r;
  logic [SLOT_W-1:0]     free_rd_r;
  logic [SLOT_W-1:0]     free_wr_r;
  logic [CNT_W-1:0]      fill_r;

  // Request registers
  mlpf_cmd_t             cmd_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [LVL_W-1:0]      pri_r;
  logic [LVL_W-1:0]      lvl_r;
  logic                  lvl_ok_r;
  mlpf_status_t          status_r;
  mlpf_status_t          status_nxt;

  mlpf_state_t           state_r;
  mlpf_state_t           state_nxt;

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [STAT_W-1:0]     out_user_r;

  // Combinational helpers
  logic                  in_fire;
  logic                  out_load;
  logic [LVL_W-1:0]      srv_lvl;
  logic                  srv_ok;
  logic [ACT_W-1:0]      active;
  logic [PRI_W-1:0]      in_pri;
  logic [LVL_W-1:0]      in_pri_c;
  logic                  push_ok;
  logic                  pop_ok;
  logic [SLOT_W-1:0]     new_slot;
  logic [VALUE_BITS-1:0] head_val;

  assign in_fire  = in_tvalid && in_tready;
  assign in_pri   = in_tdata[VALUE_BITS +: PRI_W];
  assign in_tready = (state_r == ST_IDLE);

  // Clamp priority to the last level
  always_comb begin
    if (int'(in_pri) >= LEVELS) begin
      in_pri_c = LVL_W'(LEVELS - 1);
    end else begin
      in_pri_c = LVL_W'(in_pri);
    end
  end

  // Find the served level and count the busy levels
  always_comb begin
    srv_lvl = '0;
    srv_ok  = 1'b0;
    active  = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0) begin
        srv_lvl = LVL_W'(l);
        srv_ok  = 1'b1;
        active  = active + ACT_W'(1);
      end
    end
  end

  // Value and link reads target the served head; heads are stable when the data is used
  assign rd_addr = heads_r[srv_lvl];

  // Update-step decode
  assign push_ok  = (state_r == ST_EXEC) && (cmd_r == CMD_PUSH) &&
                    (held_r != CNT_W'(CAPACITY));
  assign pop_ok   = (state_r == ST_EXEC) && (cmd_r == CMD_POP) && lvl_ok_r;
  // Unwritten ring entries are taken to hold their own index
  assign new_slot = (fill_r > CNT_W'(free_rd_r)) ? free_q : free_rd_r;

  assign val_we  = push_ok;
  assign val_wa  = new_slot;
  assign link_we = push_ok && (cnt_r[pri_r] != '0);
  assign link_wa = tails_r[pri_r];
  assign free_we = pop_ok;

  // Status of the update step
  always_comb begin
    status_nxt = STAT_OK;
    if (cmd_r == CMD_PUSH && held_r == CNT_W'(CAPACITY)) begin
      status_nxt = STAT_PUSH_FULL;
    end else if (cmd_r == CMD_POP && !lvl_ok_r) begin
      status_nxt = STAT_POP_EMPTY;
    end
  end

  // Value store
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= value_r;
    end
    val_q <= val_mem[rd_addr];
  end

  // Link store
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= new_slot;
    end
    link_q <= link_mem[rd_addr];
  end

  // Free-slot ring
  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[free_wr_r] <= heads_r[lvl_r];
    end
    free_q <= free_mem[free_rd_r];
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and result load
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = ST_HEAD;
      ST_HEAD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Capture the request and the update-step status
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= mlpf_cmd_t'(in_tuser);
      value_r  <= in_tdata[VALUE_BITS-1:0];
      pri_r    <= in_pri_c;
      lvl_r    <= srv_lvl;
      lvl_ok_r <= srv_ok;
    end
    if (state_r == ST_EXEC) begin
      status_r <= status_nxt;
    end
  end

  // Counts and ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) begin
        cnt_r[l] <= '0;
      end
      held_r    <= '0;
      free_rd_r <= '0;
      free_wr_r <= '0;
      fill_r    <= '0;
    end else if (push_ok) begin
      cnt_r[pri_r] <= cnt_r[pri_r] + CNT_W'(1);
      held_r       <= held_r + CNT_W'(1);
      free_rd_r    <= ring_next(free_rd_r);
    end else if (pop_ok) begin
      cnt_r[lvl_r] <= cnt_r[lvl_r] - CNT_W'(1);
      held_r       <= held_r - CNT_W'(1);
      free_wr_r    <= ring_next(free_wr_r);
      if (fill_r != CNT_W'(CAPACITY)) begin
        fill_r <= fill_r + CNT_W'(1);
      end
    end
  end

  // Level head and tail pointers
  always_ff @(posedge clk) begin
    if (push_ok) begin
      if (cnt_r[pri_r] == '0) begin
        heads_r[pri_r] <= new_slot;
      end
      tails_r[pri_r] <= new_slot;
    end else if (pop_ok && cnt_r[lvl_r] > CNT_W'(1)) begin
      heads_r[lvl_r] <= link_q;
    end
  end

  // Result register
  assign head_val = srv_ok ? val_q : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {1'b0, active, cnt_r[pri_r], held_r, (held_r == '0), head_val};
      out_user_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

>>> hdl/mlpf_checker.sv
// ----------------------------------------------------------------------------
// mlpf_checker
// Port-level checks for the multi-level priority FIFO core.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpf_checker
  import mlpf_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [STAT_W-1:0]     out_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result dropped or changed while stalled");

  // Drop the output after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Empty flag agrees with the total count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32] == (out_tdata[41:33] == '0)))
    else $error("empty flag disagrees with total count");

  // An empty queue reports no head and no busy level
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[31:0] == '0 && out_tdata[54:51] == '0)
    else $error("empty queue reports a head or busy level");

  // Level count never exceeds total; busy levels and total stay in range
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[50:42] <= out_tdata[41:33] &&
                   int'(out_tdata[54:51]) <= LEVELS &&
                   int'(out_tdata[41:33]) <= CAPACITY)
    else $error("inconsistent counts in result");

endmodule

bind multi_level_priority_fifo_core mlpf_checker u_mlpf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
